// ===== rtl/mss_pkg.sv =====
// Package for the masked signature scanner.
// Holds the word types, configuration layout, register indexes and sizes.
// No dependencies; every other file in rtl/ refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package mss_pkg;

    // Sizes fixed by the register layout
    localparam int MAX_PATTERN_BYTES = 32;
    localparam int PAT_IDX_W         = $clog2(MAX_PATTERN_BYTES);
    localparam int PATTERN_BYTES_DEF = 32;
    localparam int LEN_W             = 6;
    localparam int ADDR_W            = 64;
    localparam int DISP_W            = 32;
    localparam int DISP_BYTES        = 4;
    localparam int DISP_CNT_W        = $clog2(DISP_BYTES);
    localparam int CFG_IDX_W         = 3;
    localparam int QUEUE_DEPTH       = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_0_7   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_8_15  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_16_23 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_24_31 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CARE_MASK = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FOLLOW    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE      = 3'd7;

    // Input word
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_region;
    } t_in_word;

    // Output word
    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] result_address;
    } t_out_word;

    // Register file contents
    typedef struct packed {
        logic [3:0][63:0]             pattern_words;
        logic [MAX_PATTERN_BYTES-1:0] care_mask;
        logic [LEN_W-1:0]             pattern_length;
        logic                         follow_mode;
        logic [ADDR_W-1:0]            region_base;
    } t_cfg;

    // Result event passed from the scanner to the address stage
    typedef struct packed {
        logic              found;
        logic              follow;
        logic [ADDR_W-1:0] match_start;
        logic [DISP_W-1:0] displacement;
        logic [LEN_W-1:0]  length;
    } t_event;

    // Queue status towards its neighbours
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

`default_nettype wire

// ===== rtl/mss_cfg.sv =====
// Configuration register file of the masked signature scanner.
// Depends on mss_pkg for the register indexes and the t_cfg layout.
`timescale 1ns / 1ps
`default_nettype none

module mss_cfg (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [mss_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [63:0]                  i_cfg_data,
    output mss_pkg::t_cfg                     o_cfg
);

    mss_pkg::t_cfg r_cfg;

    // Writes are taken every cycle
    assign o_cfg_ready = 1'b1;

    // Register write decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern_words  <= '0;
            r_cfg.care_mask      <= '1;
            r_cfg.pattern_length <= mss_pkg::LEN_W'(1);
            r_cfg.follow_mode    <= 1'b0;
            r_cfg.region_base    <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mss_pkg::CFG_PAT_0_7:   r_cfg.pattern_words[0] <= i_cfg_data;
                mss_pkg::CFG_PAT_8_15:  r_cfg.pattern_words[1] <= i_cfg_data;
                mss_pkg::CFG_PAT_16_23: r_cfg.pattern_words[2] <= i_cfg_data;
                mss_pkg::CFG_PAT_24_31: r_cfg.pattern_words[3] <= i_cfg_data;
                mss_pkg::CFG_CARE_MASK: begin
                    r_cfg.care_mask <= i_cfg_data[mss_pkg::MAX_PATTERN_BYTES-1:0];
                end
                mss_pkg::CFG_LENGTH: begin
                    r_cfg.pattern_length <= i_cfg_data[mss_pkg::LEN_W-1:0];
                end
                mss_pkg::CFG_FOLLOW:    r_cfg.follow_mode <= i_cfg_data[0];
                mss_pkg::CFG_BASE:      r_cfg.region_base <= i_cfg_data;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== rtl/mss_front.sv =====
// Front end of the masked signature scanner: byte window, masked compare,
// scan phase and displacement collection. Emits one event per result.
// Depends on mss_pkg for word, configuration and event types.
`timescale 1ns / 1ps
`default_nettype none

module mss_front #(
    parameter int PATTERN_BYTES = mss_pkg::PATTERN_BYTES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire mss_pkg::t_in_word i_word,
    input  wire mss_pkg::t_cfg     i_cfg,
    output logic                   o_push,
    output mss_pkg::t_event        o_event
);

    localparam int LEN_W  = mss_pkg::LEN_W;
    localparam int FILL_W = $clog2(PATTERN_BYTES + 1);
    localparam int IDX_W  = mss_pkg::PAT_IDX_W;
    localparam int CNT_W  = mss_pkg::DISP_CNT_W;

    // Scan phase codes; the spare code acts like the phase after a match
    localparam logic [1:0] PH_SEARCH  = 2'd0;
    localparam logic [1:0] PH_COLLECT = 2'd1;
    localparam logic [1:0] PH_DONE    = 2'd2;

    logic [7:0]               r_window [PATTERN_BYTES];
    logic [7:0]               n_window [PATTERN_BYTES];
    logic [FILL_W-1:0]        r_fill, n_fill, w_fill_inc;
    logic [mss_pkg::ADDR_W-1:0] r_pos, n_pos;
    logic [1:0]               r_phase, n_phase;
    logic [mss_pkg::ADDR_W-1:0] r_match_start, n_match_start, w_match_start;
    logic [mss_pkg::DISP_W-1:0] r_disp, n_disp;
    logic [CNT_W-1:0]         r_disp_cnt, n_disp_cnt;

    logic [LEN_W-1:0]         w_len;
    logic [7:0]               w_pat [mss_pkg::MAX_PATTERN_BYTES];
    logic [PATTERN_BYTES-1:0] w_hit;
    logic                     w_match;

    // Effective length: zero acts as one, clamp to the window size
    always_comb begin
        if (i_cfg.pattern_length == '0) begin
            w_len = LEN_W'(1);
        end else if (i_cfg.pattern_length > LEN_W'(PATTERN_BYTES)) begin
            w_len = LEN_W'(PATTERN_BYTES);
        end else begin
            w_len = i_cfg.pattern_length;
        end
    end

    // Pattern bytes unpacked from the four configuration words
    for (genvar k = 0; k < mss_pkg::MAX_PATTERN_BYTES; k++) begin : g_pat
        assign w_pat[k] = i_cfg.pattern_words[k / 8][(k % 8) * 8 +: 8];
    end

    // Window after shifting in the new byte; slot 0 holds the newest byte
    always_comb begin
        n_window[0] = i_word.data_byte;
        for (int k = 1; k < PATTERN_BYTES; k++) begin
            n_window[k] = r_window[k - 1];
        end
    end

    // Per-slot compare: slot j faces pattern byte (len - 1 - j)
    for (genvar j = 0; j < PATTERN_BYTES; j++) begin : g_cmp
        logic [LEN_W-1:0] w_sel;
        assign w_sel    = w_len - LEN_W'(j) - LEN_W'(1);
        assign w_hit[j] = (LEN_W'(j) >= w_len)
                       || !i_cfg.care_mask[w_sel[IDX_W-1:0]]
                       || (n_window[j] == w_pat[w_sel[IDX_W-1:0]]);
    end

    assign w_fill_inc = (r_fill == FILL_W'(PATTERN_BYTES)) ? r_fill : r_fill + FILL_W'(1);
    assign w_match    = (LEN_W'(w_fill_inc) >= w_len) && (&w_hit);

    // Start address of a match ending on the current byte
    assign w_match_start = i_cfg.region_base + r_pos
                         - mss_pkg::ADDR_W'(w_len) + mss_pkg::ADDR_W'(1);

    // Phase and event logic
    always_comb begin
        n_fill        = r_fill;
        n_pos         = r_pos;
        n_phase       = r_phase;
        n_match_start = r_match_start;
        n_disp        = r_disp;
        n_disp_cnt    = r_disp_cnt;
        o_push        = 1'b0;
        o_event       = '0;
        o_event.length = w_len;

        if (i_accept) begin
            n_pos = r_pos + mss_pkg::ADDR_W'(1);
            unique case (r_phase)
                PH_SEARCH: begin
                    n_fill = w_fill_inc;
                    if (w_match) begin
                        n_match_start = w_match_start;
                        if (i_cfg.follow_mode) begin
                            n_phase    = PH_COLLECT;
                            n_disp_cnt = '0;
                        end else begin
                            n_phase             = PH_DONE;
                            o_push              = 1'b1;
                            o_event.found       = 1'b1;
                            o_event.match_start = w_match_start;
                        end
                    end
                    if (i_word.end_of_region && !o_push) begin
                        o_push        = 1'b1;
                        o_event.found = 1'b0;
                    end
                end
                PH_COLLECT: begin
                    // little-endian displacement, one byte lane per word
                    n_disp[r_disp_cnt * 8 +: 8] = i_word.data_byte;
                    if (r_disp_cnt == CNT_W'(mss_pkg::DISP_BYTES - 1)) begin
                        n_phase              = PH_DONE;
                        o_push               = 1'b1;
                        o_event.found        = 1'b1;
                        o_event.follow       = 1'b1;
                        o_event.match_start  = r_match_start;
                        o_event.displacement = n_disp;
                    end else begin
                        n_disp_cnt = r_disp_cnt + CNT_W'(1);
                        if (i_word.end_of_region) begin
                            o_push        = 1'b1;
                            o_event.found = 1'b0;
                        end
                    end
                end
                default: begin
                    // after a match: bytes are ignored until the marker
                end
            endcase

            // End of region re-arms the search
            if (i_word.end_of_region) begin
                n_fill     = '0;
                n_pos      = '0;
                n_phase    = PH_SEARCH;
                n_disp_cnt = '0;
            end
        end
    end

    // Window taps hold payload only
    always_ff @(posedge i_clk) begin
        if (i_accept && r_phase == PH_SEARCH) begin
            for (int k = 0; k < PATTERN_BYTES; k++) begin
                r_window[k] <= n_window[k];
            end
        end
        r_match_start <= n_match_start;
        r_disp        <= n_disp;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_pos      <= '0;
            r_phase    <= PH_SEARCH;
            r_disp_cnt <= '0;
        end else begin
            r_fill     <= n_fill;
            r_pos      <= n_pos;
            r_phase    <= n_phase;
            r_disp_cnt <= n_disp_cnt;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mss_queue.sv =====
// Short event queue between the scanner front end and the address stage.
// Depends on mss_pkg for the event and status types.
`timescale 1ns / 1ps
`default_nettype none

module mss_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire mss_pkg::t_event    i_event,
    input  wire logic               i_pop,
    output mss_pkg::t_event         o_head,
    output mss_pkg::t_queue_status  o_status
);

    localparam int DEPTH = mss_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mss_pkg::t_event r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push, w_pop;

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign w_push = i_push && !o_status.full;
    assign w_pop  = i_pop && !o_status.empty;
    assign o_head = r_slot[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_event;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + CNT_W'(w_push) - CNT_W'(w_pop);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mss_back.sv =====
// Back end of the masked signature scanner: resolves the result address
// and holds the output word. Depends on mss_pkg for the event and word types.
`timescale 1ns / 1ps
`default_nettype none

module mss_back (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire mss_pkg::t_event        i_head,
    input  wire mss_pkg::t_queue_status i_status,
    output logic                        o_pop,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output mss_pkg::t_out_word          o_out_data
);

    logic                       r_valid;
    mss_pkg::t_out_word         r_word;
    logic [mss_pkg::ADDR_W-1:0] w_target;

    // Take the next event whenever the output register is free or draining
    assign o_pop = !i_status.empty && (!r_valid || !i_out_stall);

    // Follow target: start + length + displacement size + displacement
    assign w_target = i_head.match_start
                    + mss_pkg::ADDR_W'(i_head.length)
                    + mss_pkg::ADDR_W'(mss_pkg::DISP_BYTES)
                    + mss_pkg::ADDR_W'(i_head.displacement);

    // Output word
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_word.found <= i_head.found;
            if (!i_head.found) begin
                r_word.result_address <= '0;
            end else if (i_head.follow) begin
                r_word.result_address <= w_target;
            end else begin
                r_word.result_address <= i_head.match_start;
            end
        end
    end

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_word;

endmodule

`default_nettype wire

// ===== rtl/masked_signature_scanner_core.sv =====
// Top level of the masked signature scanner.
// Instantiates mss_cfg, mss_front, mss_queue and mss_back; types from mss_pkg.
//
//   Channel  Dir  Handshake                   Word
//   in       in   i_in_valid / o_in_stall     i_in_data  (data_byte, end_of_region)
//   out      out  o_out_valid / i_out_stall   o_out_data (found, result_address)
//   cfg      in   i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// One byte is taken every cycle while o_in_stall is low; the masked window
// compare is parallel combinational logic in the front end. A result word
// passes through the event queue, then the output register.
// Reset is synchronous and active low; it clears all control state.
// o_in_stall rises while the two-entry event queue is full, which only
// happens when the output is held back by i_out_stall.
`timescale 1ns / 1ps
`default_nettype none

module masked_signature_scanner_core #(
    parameter int PATTERN_BYTES = mss_pkg::PATTERN_BYTES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire mss_pkg::t_in_word             i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output mss_pkg::t_out_word                 o_out_data,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [mss_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [63:0]                   i_cfg_data
);

    mss_pkg::t_cfg          w_cfg;
    mss_pkg::t_event        w_push_event, w_head;
    mss_pkg::t_queue_status w_status;
    logic                   w_accept, w_push, w_pop;

    // Input word is taken unless the event queue is full
    assign o_in_stall = w_status.full;
    assign w_accept   = i_in_valid && !o_in_stall;

    mss_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    mss_front #(
        .PATTERN_BYTES (PATTERN_BYTES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_word   (i_in_data),
        .i_cfg    (w_cfg),
        .o_push   (w_push),
        .o_event  (w_push_event)
    );

    mss_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_event  (w_push_event),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_status)
    );

    mss_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_status    (w_status),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

// ===== tb/masked_signature_scanner_core_test.sv =====
// Self-checking test of masked_signature_scanner_core: directed and random byte regions.
// Holds its own scanner model and register copy; uses mss_pkg for word types and indexes.
`timescale 1ns / 1ps

module masked_signature_scanner_core_test;
    import mss_pkg::*;

    typedef enum logic [1:0] {HUNTING, READING_DISP, SETTLED} t_hunt;

    // Clock, reset and block inputs, all known from time zero
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    t_in_word             i_in_data   = '0;
    logic                 i_out_stall = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [63:0]          i_cfg_data  = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    t_out_word            o_out_data;
    logic                 o_cfg_ready;

    masked_signature_scanner_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Register copy, reset values
    logic [63:0] sig_words [4] = '{default: '0};
    logic [31:0] sig_care      = '1;
    logic [5:0]  sig_len       = 6'd1;
    logic        sig_follow    = 1'b0;
    logic [63:0] sig_base      = '0;

    // Scanner state copy
    logic [7:0]  recent_bytes [MAX_PATTERN_BYTES];
    int unsigned recent_count;
    logic [63:0] stream_pos;
    t_hunt       hunt_state;
    logic [63:0] hit_addr;
    logic [31:0] disp_acc;
    logic [1:0]  disp_seen;

    t_in_word  bytes_to_send [$];
    t_out_word reports_due   [$];
    t_out_word due_word;

    int items_queued  = 0;
    int bytes_taken   = 0;
    int reports_seen  = 0;
    int hits_seen     = 0;
    int setups_loaded = 0;
    int mismatches    = 0;
    int in_gap        = 0;
    int out_hold      = 0;
    bit in_calm       = 1'b0;
    bit out_calm      = 1'b0;

    function automatic int unsigned active_len();
        if (sig_len == 0) return 1;
        if (sig_len > MAX_PATTERN_BYTES) return MAX_PATTERN_BYTES;
        return sig_len;
    endfunction

    function automatic logic [7:0] sig_byte(input int unsigned i);
        return sig_words[i / 8][(i % 8) * 8 +: 8];
    endfunction

    function automatic bit window_hit(input int unsigned len);
        if (recent_count < len) return 1'b0;
        for (int unsigned i = 0; i < len; i++) begin
            if (sig_care[i] && recent_bytes[len - 1 - i] != sig_byte(i)) return 1'b0;
        end
        return 1'b1;
    endfunction

    function void note_fault(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("%0t ns: %s", $time, msg);
    endfunction

    task automatic clear_hunt();
        foreach (recent_bytes[i]) recent_bytes[i] = 8'h00;
        recent_count = 0;
        stream_pos   = '0;
        hunt_state   = HUNTING;
        hit_addr     = '0;
        disp_acc     = '0;
        disp_seen    = '0;
    endtask

    task automatic owe_report(input logic hit, input logic [63:0] addr);
        t_out_word r;
        r.found          = hit;
        r.result_address = addr;
        reports_due.push_back(r);
    endtask

    // Advance the scanner copy by one accepted word, queueing any report it owes
    task automatic scan_byte(input t_in_word w);
        logic [63:0] at;
        int unsigned len;
        bit          owed;
        at         = stream_pos;
        stream_pos = at + 64'd1;
        owed       = 1'b0;
        case (hunt_state)
            HUNTING: begin
                len = active_len();
                for (int i = MAX_PATTERN_BYTES - 1; i > 0; i--)
                    recent_bytes[i] = recent_bytes[i - 1];
                recent_bytes[0] = w.data_byte;
                if (recent_count < MAX_PATTERN_BYTES) recent_count++;
                if (window_hit(len)) begin
                    hit_addr = sig_base + at - 64'(len - 1);
                    if (sig_follow) begin
                        hunt_state = READING_DISP;
                        disp_acc   = '0;
                        disp_seen  = '0;
                    end else begin
                        hunt_state = SETTLED;
                        owe_report(1'b1, hit_addr);
                        owed = 1'b1;
                    end
                end
                if (w.end_of_region && !owed) owe_report(1'b0, '0);
            end
            READING_DISP: begin
                disp_acc |= 32'(w.data_byte) << (disp_seen * 8);
                if (disp_seen == 2'd3) begin
                    hunt_state = SETTLED;
                    owe_report(1'b1, hit_addr + 64'(active_len()) + 64'd4 + {32'd0, disp_acc});
                end else begin
                    disp_seen++;
                    if (w.end_of_region) owe_report(1'b0, '0);
                end
            end
            default: ;
        endcase
        if (w.end_of_region) clear_hunt();
    endtask

    // Input side: words from the pending queue, random gaps between them
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                int gap;
                scan_byte(i_in_data);
                bytes_taken++;
                if ($urandom_range(0, 49) == 0) in_calm = !in_calm;
                gap = in_calm ? 0 : $urandom_range(0, 5);
                if (gap == 0 && bytes_to_send.size() != 0) begin
                    i_in_data <= bytes_to_send.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                    in_gap     <= (gap > 0) ? gap - 1 : 0;
                end
            end else if (!i_in_valid) begin
                if (in_gap > 0) begin
                    in_gap <= in_gap - 1;
                end else if (bytes_to_send.size() != 0) begin
                    i_in_data  <= bytes_to_send.pop_front();
                    i_in_valid <= 1'b1;
                end
            end
        end
    end

    // Output side: check each accepted word, then stall for a random spell
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ($urandom_range(0, 199) == 0) out_calm = !out_calm;
            if (o_out_valid && !i_out_stall) begin
                int hold;
                reports_seen++;
                if (o_out_data.found) hits_seen++;
                if (reports_due.size() == 0) begin
                    note_fault($sformatf("unexpected result: found %0d address %h",
                                         o_out_data.found, o_out_data.result_address));
                end else begin
                    due_word = reports_due.pop_front();
                    if (o_out_data.found !== due_word.found)
                        note_fault($sformatf("found: expected %0d got %0d",
                                             due_word.found, o_out_data.found));
                    if (o_out_data.result_address !== due_word.result_address)
                        note_fault($sformatf("result_address: expected %h got %h",
                                             due_word.result_address,
                                             o_out_data.result_address));
                end
                hold = out_calm ? 0 : $urandom_range(0, 5);
                i_out_stall <= (hold > 0);
                out_hold    <= (hold > 0) ? hold - 1 : 0;
            end else if (i_out_stall) begin
                if (out_hold == 0) i_out_stall <= 1'b0;
                else out_hold <= out_hold - 1;
            end else if (!out_calm && $urandom_range(0, 15) == 0) begin
                // stall with nothing waiting, so a result can meet it head on
                i_out_stall <= 1'b1;
                out_hold    <= $urandom_range(0, 4);
            end
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_PAT_0_7:   sig_words[0] = value;
            CFG_PAT_8_15:  sig_words[1] = value;
            CFG_PAT_16_23: sig_words[2] = value;
            CFG_PAT_24_31: sig_words[3] = value;
            CFG_CARE_MASK: sig_care     = value[31:0];
            CFG_LENGTH:    sig_len      = value[5:0];
            CFG_FOLLOW:    sig_follow   = value[0];
            CFG_BASE:      sig_base     = value;
            default: ;
        endcase
    endtask

    task automatic load_setup(input logic [63:0] w0, input logic [63:0] w1,
                              input logic [63:0] w2, input logic [63:0] w3,
                              input logic [31:0] care, input logic [5:0] len,
                              input logic follow, input logic [63:0] base);
        cfg_write(CFG_PAT_0_7, w0);
        cfg_write(CFG_PAT_8_15, w1);
        cfg_write(CFG_PAT_16_23, w2);
        cfg_write(CFG_PAT_24_31, w3);
        cfg_write(CFG_CARE_MASK, {32'd0, care});
        cfg_write(CFG_LENGTH, {58'd0, len});
        cfg_write(CFG_FOLLOW, {63'd0, follow});
        cfg_write(CFG_BASE, base);
        setups_loaded++;
    endtask

    // Wait until every word is sent and every result is in, then let the pipe empty
    task automatic wait_quiet();
        while (bytes_to_send.size() != 0 || i_in_valid || reports_due.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic queue_byte(input logic [7:0] b, input bit last);
        t_in_word w;
        w.data_byte     = b;
        w.end_of_region = last;
        bytes_to_send.push_back(w);
        items_queued++;
    endtask

    // Narrow alphabet gives overlapping and partial matches
    function automatic logic [7:0] pick_byte(input bit narrow);
        if (!narrow) return 8'($urandom);
        case ($urandom_range(0, 2))
            0:       return 8'h00;
            1:       return 8'hff;
            default: return 8'h5a;
        endcase
    endfunction

    task automatic shuffle_setup(output bit narrow);
        logic [63:0] words [4];
        logic [31:0] care;
        logic [5:0]  len;
        logic [63:0] base;
        narrow = ($urandom_range(0, 2) == 0);
        for (int w = 0; w < 4; w++)
            for (int b = 0; b < 8; b++) words[w][b * 8 +: 8] = pick_byte(narrow);
        case ($urandom_range(0, 9))
            0:       len = 6'd0;
            1:       len = 6'($urandom_range(33, 63));
            2:       len = 6'd32;
            3:       len = 6'($urandom_range(9, 31));
            default: len = 6'($urandom_range(1, 8));
        endcase
        case ($urandom_range(0, 5))
            0:       care = '0;
            1:       care = '1;
            default: care = $urandom;
        endcase
        case ($urandom_range(0, 4))
            0:       base = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 40));
            1:       base = '0;
            default: base = {$urandom, $urandom};
        endcase
        load_setup(words[0], words[1], words[2], words[3], care, len,
                   1'($urandom_range(0, 1)), base);
    endtask

    // One region: noise, then mostly the pattern (sometimes spoilt) and its displacement
    task automatic send_region(input bit narrow, input bit keep_open);
        logic [7:0]  seq [$];
        logic [7:0]  b;
        int unsigned len, flip, keep;
        bit          spoil;
        len = active_len();
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 2)) seq.push_back(pick_byte(narrow));
        end else begin
            repeat ($urandom_range(0, 10)) seq.push_back(pick_byte(narrow));
            if ($urandom_range(0, 3) != 0) begin
                spoil = ($urandom_range(0, 5) == 0);
                flip  = $urandom_range(0, len - 1);
                for (int unsigned i = 0; i < len; i++) begin
                    b = sig_care[i] ? sig_byte(i) : pick_byte(narrow);
                    if (spoil && i == flip) b ^= 8'(1 << $urandom_range(0, 7));
                    seq.push_back(b);
                end
                if (sig_follow) repeat (4) seq.push_back(8'($urandom));
            end
            repeat ($urandom_range(0, 6)) seq.push_back(pick_byte(narrow));
            if (seq.size() == 0) seq.push_back(pick_byte(narrow));
            if ($urandom_range(0, 5) == 0) begin
                keep = $urandom_range(1, seq.size());
                while (seq.size() > keep) void'(seq.pop_back());
            end
        end
        foreach (seq[k]) queue_byte(seq[k], !keep_open && (k == seq.size() - 1));
    endtask

    // Stimulus
    initial begin
        bit narrow;
        int regions;
        clear_hunt();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings; a marker after a hit gives nothing
        queue_byte(8'hff, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h00, 1'b1);
        wait_quiet();

        // Length zero acts as one; start address wraps to zero
        load_setup('1, '1, '1, '1, '1, 6'd0, 1'b0, '1);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hff, 1'b1);
        wait_quiet();

        // Trailing wildcard in follow mode: displacement with top bit set, fourth byte last;
        // then a hit on the final byte, then a region ending mid-displacement
        load_setup(64'h0000_0000_0033_2211, '0, '0, '0, 32'h0000_0003, 6'd3, 1'b1,
                   64'h0000_0000_0000_1000);
        queue_byte(8'h11, 1'b0);
        queue_byte(8'h22, 1'b0);
        queue_byte(8'h99, 1'b0);
        queue_byte(8'h04, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h80, 1'b1);
        queue_byte(8'h11, 1'b0);
        queue_byte(8'h22, 1'b0);
        queue_byte(8'h00, 1'b1);
        queue_byte(8'h11, 1'b0);
        queue_byte(8'h22, 1'b0);
        queue_byte(8'h33, 1'b0);
        queue_byte(8'hff, 1'b0);
        queue_byte(8'hff, 1'b1);
        wait_quiet();

        // Pattern of wildcards only hits once the window holds enough bytes
        load_setup(64'h0000_0000_0000_5a5a, '1, '0, '1, '0, 6'd2, 1'b0,
                   64'h8000_0000_0000_0000);
        queue_byte(8'h5a, 1'b0);
        queue_byte(8'ha5, 1'b1);
        wait_quiet();

        // Random phases; a region is sometimes left open across a settings change
        while (items_queued < 1725) begin
            shuffle_setup(narrow);
            regions = $urandom_range(1, 6);
            for (int r = 0; r < regions; r++)
                send_region(narrow, r == regions - 1 && $urandom_range(0, 7) == 0);
            wait_quiet();
        end

        repeat (10) @(posedge i_clk);
        if (reports_due.size() != 0)
            note_fault($sformatf("%0d results never arrived", reports_due.size()));
        $display("%0d bytes scanned under %0d register settings", bytes_taken, setups_loaded);
        $display("%0d results checked: %0d found, %0d not found, %0d mismatches",
                 reports_seen, hits_seen, reports_seen - hits_seen, mismatches);
        if (mismatches == 0) begin
            $display("masked_signature_scanner_core_test: clean");
        end else begin
            $display("masked_signature_scanner_core_test: errors");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5000000;
        $display("timeout: %0d words still to send, %0d results due",
                 bytes_to_send.size(), reports_due.size());
        $display("masked_signature_scanner_core_test: errors");
        $finish;
    end

endmodule
